>>> hw/rtl/sha256_block_chain_macros.svh
// Assertion macros for the SHA-256 block chain.
// Expects clk and rst_n in the scope of the use.
`ifndef SHA256_BLOCK_CHAIN_MACROS_SVH
`define SHA256_BLOCK_CHAIN_MACROS_SVH

// Condition holds at every edge outside reset.
`define SHABC_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Trigger at one edge implies the condition at the next edge.
`define SHABC_ASSERT_NEXT(name, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> hw/rtl/sha256bc_pkg.sv
// Shared types, constants and functions of the SHA-256 block chain.
// No dependencies; used by every other file of the block except the macro header.
`timescale 1ns / 1ps

package sha256bc_pkg;

    localparam int WORD_W     = 32;
    localparam int CHAIN_N    = 8;
    localparam int BLOCK_N    = 16;
    localparam int ROUNDS     = 64;
    localparam int CNT_W      = 4;
    localparam int ROUND_W    = 6;
    localparam int IDX_W      = 3;

    localparam logic [WORD_W-1:0] INIT_CHAIN [CHAIN_N] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    // Control from the sequencer to the message schedule.
    typedef struct packed {
        logic push;     // shift an input word into the window
        logic step;     // shift the next expanded word into the window
    } sched_ctl_t;

    // Control from the sequencer to the round unit.
    typedef struct packed {
        logic               iv_chain;   // reload the chain with the initial value
        logic               load_work;  // load working variables
        logic               work_iv;    // load them from the initial value
        logic               step;       // run one round
        logic               fold;       // add working variables into the chain
        logic [ROUND_W-1:0] round;      // round number
        logic [IDX_W-1:0]   rd_idx;     // chain word to read out
    } rnd_ctl_t;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

endpackage

>>> hw/rtl/sha256bc_if.sv
// Stream interfaces of the SHA-256 block chain: message words in, digest words out.
// Depends on sha256bc_pkg for widths.
`timescale 1ns / 1ps

interface sha256bc_msg_if;
    logic                              valid;
    logic                              ready;
    logic [sha256bc_pkg::WORD_W-1:0]   message_word;
    logic                              start_of_message;
    logic                              end_of_message;

    modport source (output valid, message_word, start_of_message, end_of_message,
                    input ready);
    modport sink   (input valid, message_word, start_of_message, end_of_message,
                    output ready);
endinterface

interface sha256bc_dig_if;
    logic                              valid;
    logic                              ready;
    logic [sha256bc_pkg::WORD_W-1:0]   digest_word;
    logic [sha256bc_pkg::IDX_W-1:0]    digest_index;
    logic                              digest_last;

    modport source (output valid, digest_word, digest_index, digest_last,
                    input ready);
    modport sink   (input valid, digest_word, digest_index, digest_last,
                    output ready);
endinterface

>>> hw/rtl/sha256bc_sched.sv
// Message schedule: 16-word sliding window that holds the block and expands it.
// Depends on sha256bc_pkg.
`timescale 1ns / 1ps

module sha256bc_sched
(
    input  logic                              clk,
    input  sha256bc_pkg::sched_ctl_t          ctl,
    input  logic [sha256bc_pkg::WORD_W-1:0]   word_in,
    output logic [sha256bc_pkg::WORD_W-1:0]   w_cur
);

    logic [sha256bc_pkg::WORD_W-1:0] win_reg [sha256bc_pkg::BLOCK_N];
    logic [sha256bc_pkg::WORD_W-1:0] sig0;
    logic [sha256bc_pkg::WORD_W-1:0] sig1;
    logic [sha256bc_pkg::WORD_W-1:0] w_new;
    logic [sha256bc_pkg::WORD_W-1:0] shift_in;

    always_comb
    begin
        sig0 = sha256bc_pkg::rotr(win_reg[1], 7) ^ sha256bc_pkg::rotr(win_reg[1], 18)
             ^ (win_reg[1] >> 3);
        sig1 = sha256bc_pkg::rotr(win_reg[14], 17) ^ sha256bc_pkg::rotr(win_reg[14], 19)
             ^ (win_reg[14] >> 10);
        w_new    = sig1 + win_reg[9] + sig0 + win_reg[0];
        shift_in = ctl.push ? word_in : w_new;
    end

    assign w_cur = win_reg[0];

    // Oldest word sits at entry 0; both loading and expansion shift toward it.
    always_ff @(posedge clk)
    begin
        if (ctl.push || ctl.step)
        begin
            for (int i = 0; i < sha256bc_pkg::BLOCK_N - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[sha256bc_pkg::BLOCK_N-1] <= shift_in;
        end
    end

endmodule

>>> hw/rtl/sha256bc_round.sv
// Round unit: working variables a..h, one compression round per cycle while step is set, and the chain.
// Depends on sha256bc_pkg.
`timescale 1ns / 1ps

module sha256bc_round
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  sha256bc_pkg::rnd_ctl_t            ctl,
    input  logic [sha256bc_pkg::WORD_W-1:0]   w_cur,
    output logic [sha256bc_pkg::WORD_W-1:0]   chain_word
);

    logic [sha256bc_pkg::WORD_W-1:0] v_reg     [sha256bc_pkg::CHAIN_N];
    logic [sha256bc_pkg::WORD_W-1:0] chain_reg [sha256bc_pkg::CHAIN_N];
    logic [sha256bc_pkg::WORD_W-1:0] big_s0;
    logic [sha256bc_pkg::WORD_W-1:0] big_s1;
    logic [sha256bc_pkg::WORD_W-1:0] ch;
    logic [sha256bc_pkg::WORD_W-1:0] mj;
    logic [sha256bc_pkg::WORD_W-1:0] t1;
    logic [sha256bc_pkg::WORD_W-1:0] t2;

    always_comb
    begin
        big_s1 = sha256bc_pkg::rotr(v_reg[4], 6) ^ sha256bc_pkg::rotr(v_reg[4], 11)
               ^ sha256bc_pkg::rotr(v_reg[4], 25);
        ch     = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1     = v_reg[7] + big_s1 + ch + sha256bc_pkg::ROUND_K[ctl.round] + w_cur;
        big_s0 = sha256bc_pkg::rotr(v_reg[0], 2) ^ sha256bc_pkg::rotr(v_reg[0], 13)
               ^ sha256bc_pkg::rotr(v_reg[0], 22);
        mj     = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2     = big_s0 + mj;
    end

    assign chain_word = chain_reg[ctl.rd_idx];

    always_ff @(posedge clk)
    begin
        if (ctl.load_work)
        begin
            for (int i = 0; i < sha256bc_pkg::CHAIN_N; i++)
            begin
                v_reg[i] <= ctl.work_iv ? sha256bc_pkg::INIT_CHAIN[i] : chain_reg[i];
            end
        end
        else if (ctl.step)
        begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sha256bc_pkg::CHAIN_N; i++)
            begin
                chain_reg[i] <= sha256bc_pkg::INIT_CHAIN[i];
            end
        end
        else if (ctl.iv_chain)
        begin
            for (int i = 0; i < sha256bc_pkg::CHAIN_N; i++)
            begin
                chain_reg[i] <= sha256bc_pkg::INIT_CHAIN[i];
            end
        end
        else if (ctl.fold)
        begin
            for (int i = 0; i < sha256bc_pkg::CHAIN_N; i++)
            begin
                chain_reg[i] <= chain_reg[i] + v_reg[i];
            end
        end
    end

endmodule

>>> hw/rtl/sha256_block_chain.sv
// SHA-256 block chain top level: sequencer, message schedule and round unit.
// Depends on sha256bc_pkg, sha256bc_if, sha256bc_sched, sha256bc_round and the macro header.
// The sixteenth word of a block holds the input while it runs 64 rounds through the
// single round unit, one round per cycle, and then a fold state adds the result into the
// chain. A word flagged end of message is followed by eight digest words, one per cycle
// while the sink is ready, and no input is taken until the last of them transfers. No padding
// is added; a partial block at the end of a message is dropped and leaves the chain as it was.
`timescale 1ns / 1ps
`include "sha256_block_chain_macros.svh"

module sha256_block_chain
(
    input  logic                   clk,
    input  logic                   rst_n,
    sha256bc_msg_if.sink           msg_in,
    sha256bc_dig_if.source         digest_out
);

    typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_FOLD, ST_EMIT} state_t;

    state_t                                state_reg;
    logic [sha256bc_pkg::CNT_W-1:0]        count_reg;
    logic [sha256bc_pkg::ROUND_W-1:0]      round_reg;
    logic [sha256bc_pkg::IDX_W-1:0]        idx_reg;
    logic                                  end_pending_reg;

    logic                                  in_xfer;
    logic                                  out_xfer;
    logic [sha256bc_pkg::CNT_W-1:0]        base_count;
    logic                                  block_full;
    sha256bc_pkg::sched_ctl_t              sched_ctl;
    sha256bc_pkg::rnd_ctl_t                rnd_ctl;
    logic [sha256bc_pkg::WORD_W-1:0]       w_cur;
    logic [sha256bc_pkg::WORD_W-1:0]       chain_word;

    localparam logic [sha256bc_pkg::CNT_W-1:0]   COUNT_LAST = '1;
    localparam logic [sha256bc_pkg::ROUND_W-1:0] ROUND_LAST = '1;
    localparam logic [sha256bc_pkg::IDX_W-1:0]   IDX_LAST   = '1;

    assign msg_in.ready = (state_reg == ST_IDLE);
    assign in_xfer      = msg_in.valid && msg_in.ready;
    assign out_xfer     = digest_out.valid && digest_out.ready;

    // Start flag clears the count before the word is placed.
    assign base_count = msg_in.start_of_message ? '0 : count_reg;
    assign block_full = (base_count == COUNT_LAST);

    always_comb
    begin
        sched_ctl.push = in_xfer;
        sched_ctl.step = (state_reg == ST_ROUND);

        rnd_ctl.iv_chain  = in_xfer && msg_in.start_of_message;
        rnd_ctl.load_work = in_xfer && block_full;
        rnd_ctl.work_iv   = msg_in.start_of_message;
        rnd_ctl.step      = (state_reg == ST_ROUND);
        rnd_ctl.fold      = (state_reg == ST_FOLD);
        rnd_ctl.round     = round_reg;
        rnd_ctl.rd_idx    = idx_reg;
    end

    sha256bc_sched u_sched
    (
        .clk     (clk),
        .ctl     (sched_ctl),
        .word_in (msg_in.message_word),
        .w_cur   (w_cur)
    );

    sha256bc_round u_round
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (rnd_ctl),
        .w_cur      (w_cur),
        .chain_word (chain_word)
    );

    assign digest_out.valid        = (state_reg == ST_EMIT);
    assign digest_out.digest_word  = chain_word;
    assign digest_out.digest_index = idx_reg;
    assign digest_out.digest_last  = (idx_reg == IDX_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            round_reg       <= '0;
            idx_reg         <= '0;
            end_pending_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        end_pending_reg <= msg_in.end_of_message;
                        idx_reg         <= '0;
                        round_reg       <= '0;
                        if (block_full)
                        begin
                            count_reg <= '0;
                            state_reg <= ST_ROUND;
                        end
                        else if (msg_in.end_of_message)
                        begin
                            // drop the partial block
                            count_reg <= '0;
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            count_reg <= base_count + 1'b1;
                        end
                    end
                end
                ST_ROUND:
                begin
                    round_reg <= round_reg + 1'b1;
                    if (round_reg == ROUND_LAST)
                    begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD:
                begin
                    state_reg <= end_pending_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT:
                begin
                    if (out_xfer)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == IDX_LAST)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `SHABC_ASSERT_ALWAYS(a_no_overlap, !(msg_in.ready && digest_out.valid), "input taken while digest pending")
    `SHABC_ASSERT_NEXT(a_full_block_stalls, in_xfer && block_full, !msg_in.ready && !digest_out.valid, "block did not start compression")
    `SHABC_ASSERT_NEXT(a_rounds_fold, state_reg == ST_ROUND && round_reg == ROUND_LAST, state_reg == ST_FOLD, "round count did not end in fold")
    `SHABC_ASSERT_NEXT(a_idx_advance, out_xfer && idx_reg != IDX_LAST, digest_out.valid && idx_reg == $past(idx_reg) + 1'b1, "digest index skipped")

endmodule
